### src/jadz_pkg.sv
// Package for the joystick axis dead-zone scaler.
// Fixed-point widths, zone source codes and pipeline side-band types; no dependencies.
`default_nettype none
package jadz_pkg;
    localparam int FRAC_BITS = 16;
    localparam int AXIS_W    = 17;
    localparam int VEC_W     = 18;
    localparam int SQ_W      = 36;               // x^2 + y^2 + z^2
    localparam int ROOT_W    = SQ_W / 2;
    localparam int SREM_W    = ROOT_W + 2;
    localparam int NUM_W     = AXIS_W + FRAC_BITS; // dividend width
    localparam int DEN_W     = FRAC_BITS + 1;
    localparam int DZ_W      = 16;
    localparam int GAIN_W    = 16;
    localparam int OUT_W     = 24;
    localparam int PROD_W    = DEN_W + 1 + GAIN_W;
    localparam int SCL_W     = PROD_W - 8;

    localparam logic [DEN_W-1:0] ONE = DEN_W'(1) << FRAC_BITS;
    localparam logic signed [OUT_W-1:0] SAT_HI = OUT_W'((32767 << FRAC_BITS) / 256);
    localparam logic signed [OUT_W-1:0] SAT_LO = OUT_W'(-(128 << FRAC_BITS));

    typedef enum logic [1:0] {
        SRC_NONE = 2'd0,
        SRC_MAG  = 2'd1,
        SRC_AXIS = 2'd2,
        SRC_RSVD = 2'd3
    } zone_src_t;

    typedef enum logic [1:0] {
        REG_DEAD_ZONE = 2'd0,
        REG_ZONE_SRC  = 2'd1,
        REG_INVERT    = 2'd2,
        REG_GAIN      = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [AXIS_W-1:0] axis;
        logic              gate;
        logic              use_min;
    } div_side_t;
endpackage
`default_nettype wire

### src/jadz_sqrt_cell.sv
// One digit cell of the pipelined integer square root (two radicand bits per cell).
// Depends on jadz_pkg.
`default_nettype none
module jadz_sqrt_cell #(
    parameter int SIDE_W = jadz_pkg::AXIS_W
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          up_valid,
    output logic                               up_ready,
    input  wire logic [jadz_pkg::SQ_W-1:0]     up_rad,
    input  wire logic [jadz_pkg::SREM_W-1:0]   up_rem,
    input  wire logic [jadz_pkg::ROOT_W-1:0]   up_root,
    input  wire logic [SIDE_W-1:0]             up_side,
    output logic                               dn_valid,
    input  wire logic                          dn_ready,
    output logic [jadz_pkg::SQ_W-1:0]          dn_rad,
    output logic [jadz_pkg::SREM_W-1:0]        dn_rem,
    output logic [jadz_pkg::ROOT_W-1:0]        dn_root,
    output logic [SIDE_W-1:0]                  dn_side
);
    logic                            valid_reg;
    logic [jadz_pkg::SREM_W+1:0]     cat;
    logic [jadz_pkg::SREM_W+1:0]     trial;
    logic                            ge;
    logic [jadz_pkg::SREM_W-1:0]     rem_next;
    logic [jadz_pkg::ROOT_W-1:0]     root_next;

    assign cat   = {up_rem, up_rad[jadz_pkg::SQ_W-1 -: 2]};
    assign trial = {2'b00, up_root, 2'b01};
    assign ge    = (cat >= trial);
    always_comb
    begin
        rem_next  = ge ? jadz_pkg::SREM_W'(cat - trial) : jadz_pkg::SREM_W'(cat);
        root_next = {up_root[jadz_pkg::ROOT_W-2:0], ge};
    end

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            dn_rad  <= {up_rad[jadz_pkg::SQ_W-3:0], 2'b00};
            dn_rem  <= rem_next;
            dn_root <= root_next;
            dn_side <= up_side;
        end
    end
endmodule
`default_nettype wire

### src/jadz_div_cell.sv
// One quotient-bit cell of the pipelined restoring divider.
// Depends on jadz_pkg.
`default_nettype none
module jadz_div_cell #(
    parameter int SIDE_W = $bits(jadz_pkg::div_side_t)
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [jadz_pkg::DEN_W-1:0]    den,
    input  wire logic                          up_valid,
    output logic                               up_ready,
    input  wire logic [jadz_pkg::NUM_W-1:0]    up_num,
    input  wire logic [jadz_pkg::DEN_W-1:0]    up_rem,
    input  wire logic [SIDE_W-1:0]             up_side,
    output logic                               dn_valid,
    input  wire logic                          dn_ready,
    output logic [jadz_pkg::NUM_W-1:0]         dn_num,
    output logic [jadz_pkg::DEN_W-1:0]         dn_rem,
    output logic [SIDE_W-1:0]                  dn_side
);
    logic                          valid_reg;
    logic [jadz_pkg::DEN_W:0]      cat;
    logic                          ge;
    logic [jadz_pkg::DEN_W-1:0]    rem_next;

    // dividend bits shift out the top, quotient bits shift in at the bottom
    assign cat      = {up_rem, up_num[jadz_pkg::NUM_W-1]};
    assign ge       = (cat >= {1'b0, den});
    assign rem_next = ge ? jadz_pkg::DEN_W'(cat - {1'b0, den}) : jadz_pkg::DEN_W'(cat);

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            dn_num  <= {up_num[jadz_pkg::NUM_W-2:0], ge};
            dn_rem  <= rem_next;
            dn_side <= up_side;
        end
    end
endmodule
`default_nettype wire

### src/joystick_axis_dead_zone_scaler.sv
// Top level of the joystick axis dead-zone scaler: squares, root cells, divider cells, gain.
// Depends on jadz_pkg, jadz_sqrt_cell and jadz_div_cell.
// Pipeline: 3 entry stages, 18 root cells, 1 select stage, 33 divider cells and
// 2 gain/saturate stages.
// Throughput: one transaction per cycle; each stage holds its item while downstream stalls.
// Reset: all stage valid bits clear; dead_zone 0, zone_source 1, invert 0, gain 256.
`default_nettype none
module joystick_axis_dead_zone_scaler (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [1:0]                         cfg_index,
    input  wire logic [15:0]                        cfg_data,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic [jadz_pkg::AXIS_W-1:0]        axis_value,
    input  wire logic signed [jadz_pkg::VEC_W-1:0]  vec_x,
    input  wire logic signed [jadz_pkg::VEC_W-1:0]  vec_y,
    input  wire logic signed [jadz_pkg::VEC_W-1:0]  vec_z,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic signed [jadz_pkg::OUT_W-1:0]       shaped_value
);
    localparam int SQRT_N = jadz_pkg::ROOT_W;
    localparam int DIV_N  = jadz_pkg::NUM_W;
    localparam int DSW    = $bits(jadz_pkg::div_side_t);
    localparam int SQ1_W  = 2 * jadz_pkg::VEC_W;

    // configuration
    logic [jadz_pkg::DZ_W-1:0]          dead_zone_reg;
    jadz_pkg::zone_src_t                zone_src_reg;
    logic                               invert_reg;
    logic signed [jadz_pkg::GAIN_W-1:0] gain_reg;
    logic [jadz_pkg::DEN_W-1:0]         dz;
    logic [jadz_pkg::DEN_W-1:0]         den;

    assign cfg_ready = 1'b1;
    assign dz  = jadz_pkg::DEN_W'(dead_zone_reg);
    assign den = jadz_pkg::ONE - dz;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dead_zone_reg <= '0;
            zone_src_reg  <= jadz_pkg::SRC_MAG;
            invert_reg    <= 1'b0;
            gain_reg      <= 16'sd256;
        end
        else if (cfg_valid)
        begin
            case (jadz_pkg::reg_idx_t'(cfg_index))
                jadz_pkg::REG_DEAD_ZONE: dead_zone_reg <= cfg_data;
                jadz_pkg::REG_ZONE_SRC:  zone_src_reg  <= jadz_pkg::zone_src_t'(cfg_data[1:0]);
                jadz_pkg::REG_INVERT:    invert_reg    <= cfg_data[0];
                jadz_pkg::REG_GAIN:      gain_reg      <= $signed(cfg_data);
                default: ;
            endcase
        end
    end

    // entry stages: input register, squares, sum
    logic v0_reg, v1_reg, v2_reg;
    logic rdy0, rdy1, rdy2;
    logic [jadz_pkg::AXIS_W-1:0]       axis0_reg, axis1_reg, axis2_reg;
    logic signed [jadz_pkg::VEC_W-1:0] x0_reg, y0_reg, z0_reg;
    logic [SQ1_W-1:0]                  sqx_reg, sqy_reg, sqz_reg;
    logic [jadz_pkg::SQ_W-1:0]         sum_reg;
    logic [SQ1_W-1:0]                  sqx_next, sqy_next, sqz_next;
    logic [jadz_pkg::SQ_W-1:0]         sum_next;

    logic [SQRT_N:0]                   s_valid;
    logic [SQRT_N:0]                   s_ready;
    logic [jadz_pkg::SQ_W-1:0]         s_rad  [SQRT_N+1];
    logic [jadz_pkg::SREM_W-1:0]       s_rem  [SQRT_N+1];
    logic [jadz_pkg::ROOT_W-1:0]       s_root [SQRT_N+1];
    logic [jadz_pkg::AXIS_W-1:0]       s_side [SQRT_N+1];

    assign in_ready = rdy0;
    assign rdy0 = !v0_reg || rdy1;
    assign rdy1 = !v1_reg || rdy2;
    assign rdy2 = !v2_reg || s_ready[0];

    assign sqx_next = SQ1_W'(x0_reg * x0_reg);
    assign sqy_next = SQ1_W'(y0_reg * y0_reg);
    assign sqz_next = SQ1_W'(z0_reg * z0_reg);
    assign sum_next = jadz_pkg::SQ_W'(sqx_reg) + jadz_pkg::SQ_W'(sqy_reg)
                    + jadz_pkg::SQ_W'(sqz_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (rdy0) v0_reg <= in_valid;
            if (rdy1) v1_reg <= v0_reg;
            if (rdy2) v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy0 && in_valid)
        begin
            axis0_reg <= axis_value;
            x0_reg    <= vec_x;
            y0_reg    <= vec_y;
            z0_reg    <= vec_z;
        end
        if (rdy1 && v0_reg)
        begin
            axis1_reg <= axis0_reg;
            sqx_reg   <= sqx_next;
            sqy_reg   <= sqy_next;
            sqz_reg   <= sqz_next;
        end
        if (rdy2 && v1_reg)
        begin
            axis2_reg <= axis1_reg;
            sum_reg   <= sum_next;
        end
    end

    // square root cell chain
    assign s_valid[0] = v2_reg;
    assign s_rad[0]   = sum_reg;
    assign s_rem[0]   = '0;
    assign s_root[0]  = '0;
    assign s_side[0]  = axis2_reg;

    for (genvar i = 0; i < SQRT_N; i++)
    begin : g_sqrt
        jadz_sqrt_cell #(.SIDE_W(jadz_pkg::AXIS_W)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (s_valid[i]),
            .up_ready (s_ready[i]),
            .up_rad   (s_rad[i]),
            .up_rem   (s_rem[i]),
            .up_root  (s_root[i]),
            .up_side  (s_side[i]),
            .dn_valid (s_valid[i+1]),
            .dn_ready (s_ready[i+1]),
            .dn_rad   (s_rad[i+1]),
            .dn_rem   (s_rem[i+1]),
            .dn_root  (s_root[i+1]),
            .dn_side  (s_side[i+1])
        );
    end

    // select stage: clamp magnitude, gate, form dividend
    logic                         v3_reg;
    logic [DIV_N:0]               d_valid;
    logic [DIV_N:0]               d_ready;
    logic [jadz_pkg::NUM_W-1:0]   d_num  [DIV_N+1];
    logic [jadz_pkg::DEN_W-1:0]   d_rem  [DIV_N+1];
    logic [DSW-1:0]               d_side [DIV_N+1];
    logic [jadz_pkg::NUM_W-1:0]   num3_reg;
    jadz_pkg::div_side_t          side3_reg;

    logic [jadz_pkg::AXIS_W-1:0]  mag;
    logic [jadz_pkg::AXIS_W-1:0]  sel_v;
    logic [jadz_pkg::AXIS_W:0]    diff;
    logic [jadz_pkg::NUM_W-1:0]   num3_next;
    jadz_pkg::div_side_t          side3_next;

    assign s_ready[SQRT_N] = !v3_reg || d_ready[0];

    always_comb
    begin
        mag = (s_root[SQRT_N] > jadz_pkg::ROOT_W'(jadz_pkg::ONE))
            ? jadz_pkg::AXIS_W'(jadz_pkg::ONE) : jadz_pkg::AXIS_W'(s_root[SQRT_N]);
        side3_next.axis    = s_side[SQRT_N];
        side3_next.use_min = 1'b0;
        side3_next.gate    = 1'b0;
        sel_v              = s_side[SQRT_N];
        case (zone_src_reg)
            jadz_pkg::SRC_NONE: ;
            jadz_pkg::SRC_MAG:
            begin
                sel_v              = mag;
                side3_next.use_min = 1'b1;
                side3_next.gate    = (mag < dz);
            end
            jadz_pkg::SRC_AXIS: side3_next.gate = (s_side[SQRT_N] < dz);
            default:            side3_next.gate = 1'b1;
        endcase
        diff = {1'b0, sel_v} - {2'b00, dead_zone_reg};
        // non-positive difference gives a zero quotient
        if (diff[jadz_pkg::AXIS_W] || diff == '0)
            num3_next = '0;
        else
            num3_next = {diff[jadz_pkg::AXIS_W-1:0], {jadz_pkg::FRAC_BITS{1'b0}}};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (s_ready[SQRT_N])
            v3_reg <= s_valid[SQRT_N];
    end

    always_ff @(posedge clk)
    begin
        if (s_ready[SQRT_N] && s_valid[SQRT_N])
        begin
            num3_reg  <= num3_next;
            side3_reg <= side3_next;
        end
    end

    // divider cell chain
    assign d_valid[0] = v3_reg;
    assign d_num[0]   = num3_reg;
    assign d_rem[0]   = '0;
    assign d_side[0]  = side3_reg;

    for (genvar j = 0; j < DIV_N; j++)
    begin : g_div
        jadz_div_cell #(.SIDE_W(DSW)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .den      (den),
            .up_valid (d_valid[j]),
            .up_ready (d_ready[j]),
            .up_num   (d_num[j]),
            .up_rem   (d_rem[j]),
            .up_side  (d_side[j]),
            .dn_valid (d_valid[j+1]),
            .dn_ready (d_ready[j+1]),
            .dn_num   (d_num[j+1]),
            .dn_rem   (d_rem[j+1]),
            .dn_side  (d_side[j+1])
        );
    end

    // gain/saturate stages: clamp quotient, invert, multiply; then pick, gate, saturate
    logic                               v4_reg, v5_reg;
    logic                               rdy4, rdy5;
    logic signed [jadz_pkg::PROD_W-1:0] prod_reg;
    jadz_pkg::div_side_t                side4_reg;
    logic signed [jadz_pkg::OUT_W-1:0]  out_reg;
    jadz_pkg::div_side_t                side_q;
    logic [jadz_pkg::DEN_W-1:0]         r_clamp;
    logic [jadz_pkg::DEN_W-1:0]         r_inv;
    logic signed [jadz_pkg::PROD_W-1:0] prod_next;
    logic signed [jadz_pkg::SCL_W-1:0]  scaled;
    logic signed [jadz_pkg::SCL_W-1:0]  axis_s;
    logic signed [jadz_pkg::SCL_W-1:0]  pick;
    logic signed [jadz_pkg::OUT_W-1:0]  out_next;

    assign side_q = jadz_pkg::div_side_t'(d_side[DIV_N]);
    assign d_ready[DIV_N] = rdy4;
    assign rdy4 = !v4_reg || rdy5;
    assign rdy5 = !v5_reg || out_ready;

    always_comb
    begin
        r_clamp = (d_num[DIV_N] > jadz_pkg::NUM_W'(jadz_pkg::ONE))
                ? jadz_pkg::ONE : d_num[DIV_N][jadz_pkg::DEN_W-1:0];
        r_inv   = invert_reg ? (jadz_pkg::ONE - r_clamp) : r_clamp;
        prod_next = jadz_pkg::PROD_W'($signed({1'b0, r_inv}) * gain_reg);
    end

    always_comb
    begin
        scaled = jadz_pkg::SCL_W'(prod_reg >>> 8);   // floor divide by 256
        axis_s = $signed(jadz_pkg::SCL_W'(side4_reg.axis));
        pick   = (side4_reg.use_min && axis_s < scaled) ? axis_s : scaled;
        if (side4_reg.gate)
            out_next = '0;
        else if (pick > jadz_pkg::SCL_W'(jadz_pkg::SAT_HI))
            out_next = jadz_pkg::SAT_HI;
        else if (pick < jadz_pkg::SCL_W'(jadz_pkg::SAT_LO))
            out_next = jadz_pkg::SAT_LO;
        else
            out_next = jadz_pkg::OUT_W'(pick);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (rdy4) v4_reg <= d_valid[DIV_N];
            if (rdy5) v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy4 && d_valid[DIV_N])
        begin
            prod_reg  <= prod_next;
            side4_reg <= side_q;
        end
        if (rdy5 && v4_reg)
            out_reg <= out_next;
    end

    assign out_valid    = v5_reg;
    assign shaped_value = out_reg;

    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("pipeline stalls with an open output");
    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(shaped_value)))
        else $error("result changed while stalled");
    a_sat_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (shaped_value <= jadz_pkg::SAT_HI))
        else $error("result above saturation limit");
endmodule
`default_nettype wire
